/* rtl/hvd_pkg.sv */
// hvd_pkg: shared widths, types, constants and constant functions for the
// haversine distance pipeline. no dependencies.
`default_nettype none

package hvd_pkg;

    // fixed-point format of angles and of values in [0,1]
    localparam int ANGLE_FRAC_BITS  = 30;
    localparam int CORDIC_STEPS_DEF = 24;

    // rotation lanes: first latitude, second latitude, half dlat, half dlon
    localparam int LANES      = 4;
    localparam int LANE_LAT1  = 0;
    localparam int LANE_LAT2  = 1;
    localparam int LANE_DLAT  = 2;
    localparam int LANE_DLON  = 3;

    localparam int XY_W   = ANGLE_FRAC_BITS + 3;
    localparam int Z_W    = ANGLE_FRAC_BITS + 2;
    localparam int ROOT_W = ANGLE_FRAC_BITS + 1;
    localparam int REM_W  = ANGLE_FRAC_BITS + 4;
    localparam int RAD_W  = 2 * ROOT_W;

    typedef logic signed [XY_W-1:0] hvd_xy_t;
    typedef logic signed [Z_W-1:0]  hvd_z_t;

    typedef struct packed {
        logic valid;
        logic bad;
    } hvd_tag_t;

    // atan(2^-i) rounded to Q30
    function automatic hvd_z_t hvd_atan(input int step);
        hvd_z_t a;
        a = '0;
        case (step)
            0:  a = hvd_z_t'(843314857);
            1:  a = hvd_z_t'(497837829);
            2:  a = hvd_z_t'(263043837);
            3:  a = hvd_z_t'(133525159);
            4:  a = hvd_z_t'(67021687);
            5:  a = hvd_z_t'(33543516);
            6:  a = hvd_z_t'(16775851);
            7:  a = hvd_z_t'(8388437);
            8:  a = hvd_z_t'(4194283);
            9:  a = hvd_z_t'(2097149);
            default: begin
                if (step <= ANGLE_FRAC_BITS + 1) begin
                    a = hvd_z_t'(((64'd1 << (ANGLE_FRAC_BITS + 1 - step)) + 64'd1) >> 1);
                end else begin
                    a = '0;
                end
            end
        endcase
        return a;
    endfunction

    // unsigned long division by shift and subtract, elaboration only
    function automatic logic [63:0] hvd_udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // squared inverse cordic gain in Q60, truncated as each factor is applied
    function automatic logic [59:0] hvd_k2(input int steps);
        logic [63:0] g;
        g = 64'd1 << 60;
        for (int i = 0; i < steps; i++) begin
            if (2 * i < 62) begin
                g = g - hvd_udiv(g, (64'd1 << (2 * i)) + 64'd1);
            end
        end
        return g[59:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/hvd_rot_cell.sv */
// hvd_rot_cell: one rotation-mode cordic step over all four angle lanes.
// depends on hvd_pkg.
`default_nettype none

module hvd_rot_cell
    import hvd_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     en,
    input  wire hvd_tag_t tag_in,
    input  wire hvd_xy_t  x_in [LANES],
    input  wire hvd_xy_t  y_in [LANES],
    input  wire hvd_z_t   z_in [LANES],
    output hvd_tag_t      tag_out,
    output hvd_xy_t       x_out [LANES],
    output hvd_xy_t       y_out [LANES],
    output hvd_z_t        z_out [LANES]
);

    localparam hvd_z_t ATN = hvd_atan(STEP);

    hvd_tag_t tag_reg;
    hvd_xy_t  x_reg [LANES];
    hvd_xy_t  y_reg [LANES];
    hvd_z_t   z_reg [LANES];
    hvd_xy_t  x_next [LANES];
    hvd_xy_t  y_next [LANES];
    hvd_z_t   z_next [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (!z_in[k][Z_W-1]) begin
                x_next[k] = x_in[k] - (y_in[k] >>> STEP);
                y_next[k] = y_in[k] + (x_in[k] >>> STEP);
                z_next[k] = z_in[k] - ATN;
            end else begin
                x_next[k] = x_in[k] + (y_in[k] >>> STEP);
                y_next[k] = y_in[k] - (x_in[k] >>> STEP);
                z_next[k] = z_in[k] + ATN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (en) begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < LANES; k++) begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                z_reg[k] <= z_next[k];
            end
        end
    end

    assign tag_out = tag_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

`default_nettype wire

/* rtl/hvd_sqrt_cell.sv */
// hvd_sqrt_cell: one result bit of a digit-by-digit square root, two lanes.
// depends on hvd_pkg.
`default_nettype none

module hvd_sqrt_cell
    import hvd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire hvd_tag_t          tag_in,
    input  wire logic [RAD_W-1:0]  rad_in  [2],
    input  wire logic [ROOT_W-1:0] root_in [2],
    input  wire logic [REM_W-1:0]  rem_in  [2],
    output hvd_tag_t               tag_out,
    output logic      [RAD_W-1:0]  rad_out  [2],
    output logic      [ROOT_W-1:0] root_out [2],
    output logic      [REM_W-1:0]  rem_out  [2]
);

    hvd_tag_t          tag_reg;
    logic [RAD_W-1:0]  rad_reg   [2];
    logic [ROOT_W-1:0] root_reg  [2];
    logic [REM_W-1:0]  rem_reg   [2];
    logic [RAD_W-1:0]  rad_next  [2];
    logic [ROOT_W-1:0] root_next [2];
    logic [REM_W-1:0]  rem_next  [2];
    logic [REM_W-1:0]  rem_sh    [2];
    logic [REM_W-1:0]  trial     [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            rem_sh[k]   = {rem_in[k][REM_W-3:0], rad_in[k][RAD_W-1:RAD_W-2]};
            trial[k]    = REM_W'({root_in[k], 2'b01});
            rad_next[k] = {rad_in[k][RAD_W-3:0], 2'b00};
            if (rem_sh[k] >= trial[k]) begin
                rem_next[k]  = rem_sh[k] - trial[k];
                root_next[k] = {root_in[k][ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[k]  = rem_sh[k];
                root_next[k] = {root_in[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (en) begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 2; k++) begin
                rad_reg[k]  <= rad_next[k];
                root_reg[k] <= root_next[k];
                rem_reg[k]  <= rem_next[k];
            end
        end
    end

    assign tag_out  = tag_reg;
    assign rad_out  = rad_reg;
    assign root_out = root_reg;
    assign rem_out  = rem_reg;

endmodule

`default_nettype wire

/* rtl/hvd_vec_cell.sv */
// hvd_vec_cell: one vectoring-mode cordic step, accumulates the angle.
// depends on hvd_pkg.
`default_nettype none

module hvd_vec_cell
    import hvd_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     en,
    input  wire hvd_tag_t tag_in,
    input  wire hvd_xy_t  x_in,
    input  wire hvd_xy_t  y_in,
    input  wire hvd_z_t   z_in,
    output hvd_tag_t      tag_out,
    output hvd_xy_t       x_out,
    output hvd_xy_t       y_out,
    output hvd_z_t        z_out
);

    localparam hvd_z_t ATN = hvd_atan(STEP);

    hvd_tag_t tag_reg;
    hvd_xy_t  x_reg, x_next;
    hvd_xy_t  y_reg, y_next;
    hvd_z_t   z_reg, z_next;

    always_comb begin
        if (!y_in[XY_W-1] && (|y_in)) begin
            x_next = x_in + (y_in >>> STEP);
            y_next = y_in - (x_in >>> STEP);
            z_next = z_in + ATN;
        end else begin
            x_next = x_in - (y_in >>> STEP);
            y_next = y_in + (x_in >>> STEP);
            z_next = z_in - ATN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (en) begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign tag_out = tag_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

`default_nettype wire

/* rtl/haversine_distance.sv */
// haversine_distance: top level of the great-circle distance pipeline.
// depends on hvd_pkg, hvd_rot_cell, hvd_sqrt_cell and hvd_vec_cell.
//
// channel   direction  handshake                      payload
// s_        in         s_tvalid / s_tready            s_tdata: four coordinates
// m_        out        m_tvalid / m_tready            m_tdata: distance, m_tuser: bad
// apb       in         psel / penable / pready        earth_radius_m at address 0
//
// one word per clock enters and leaves while m_tready stays high; a word's path
// to m_tvalid is set mostly by the two cordic rows and the 31-cell square root row.
// aresetn is synchronous, clears all valid flags and loads the default radius.
// the whole row moves on one enable; a two-entry output stage keeps s_tready
// high while one finished word waits on m_tready.
`default_nettype none

module haversine_distance
    import hvd_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // s_tdata: first_latitude, first_longitude, second_latitude, second_longitude
    input  wire logic [127:0] s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // m_tdata: distance_m [25:0], zero fill above
    output logic [31:0]       m_tdata,
    // m_tuser: bad_point
    output logic              m_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int F = ANGLE_FRAC_BITS;
    localparam int MAG_W = 29;
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] UDEG_RAD_Q60 = (PI_Q60 + 64'd90000000) / 64'd180000000;
    localparam logic [34:0] UDEG_RAD = UDEG_RAD_Q60[34:0];
    localparam logic [63:0] PI_F_WIDE = (PI_Q60 + (64'd1 << (59 - F))) >> (60 - F);
    localparam logic [31:0] PI_F = PI_F_WIDE[31:0];
    localparam logic [31:0] HALF_PI_F = PI_F >> 1;
    localparam logic [59:0] K2 = hvd_k2(CORDIC_STEPS);
    localparam logic [ROOT_W-1:0] ONE = ROOT_W'(1) << F;
    localparam logic signed [31:0] LAT_LIMIT = 32'sd90000000;
    localparam logic signed [31:0] LON_LIMIT = 32'sd180000000;
    localparam logic [25:0] DIST_MAX = 26'h3FFFFFF;
    localparam logic [23:0] RADIUS_RESET = 24'd6372800;
    localparam logic REG_EARTH_RADIUS = 1'b0;

    // ---------------- configuration port ----------------
    logic [23:0] radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_EARTH_RADIUS) begin
            radius_reg <= pwdata[23:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EARTH_RADIUS) ? {8'd0, radius_reg} : 32'd0;

    // ---------------- global advance ----------------
    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------- s0: range check, magnitudes ----------------
    logic signed [31:0] la1, lo1, la2, lo2;
    logic signed [32:0] dlat, dlon;
    logic [32:0]        dlat_abs, dlon_abs;
    logic [31:0]        la1_abs, la2_abs;
    logic               bad_next;

    assign la1 = s_tdata[31:0];
    assign lo1 = s_tdata[63:32];
    assign la2 = s_tdata[95:64];
    assign lo2 = s_tdata[127:96];

    always_comb begin
        dlat     = {la2[31], la2} - {la1[31], la1};
        dlon     = {lo2[31], lo2} - {lo1[31], lo1};
        dlat_abs = dlat[32] ? 33'(-dlat) : 33'(dlat);
        dlon_abs = dlon[32] ? 33'(-dlon) : 33'(dlon);
        la1_abs  = la1[31] ? 32'(-la1) : 32'(la1);
        la2_abs  = la2[31] ? 32'(-la2) : 32'(la2);
        bad_next = (la1 < -LAT_LIMIT) || (la1 > LAT_LIMIT) ||
                   (la2 < -LAT_LIMIT) || (la2 > LAT_LIMIT) ||
                   (lo1 < -LON_LIMIT) || (lo1 > LON_LIMIT) ||
                   (lo2 < -LON_LIMIT) || (lo2 > LON_LIMIT);
    end

    hvd_tag_t         s0_tag_reg;
    logic [MAG_W-1:0] s0_mag_reg [LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_tag_reg <= '0;
        end else if (en) begin
            s0_tag_reg.valid <= s_tvalid;
            s0_tag_reg.bad   <= bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_mag_reg[LANE_LAT1] <= la1_abs[MAG_W-1:0];
            s0_mag_reg[LANE_LAT2] <= la2_abs[MAG_W-1:0];
            s0_mag_reg[LANE_DLAT] <= dlat_abs[MAG_W-1:0];
            s0_mag_reg[LANE_DLON] <= dlon_abs[MAG_W-1:0];
        end
    end

    // ---------------- s1: degree to radian partial products ----------------
    hvd_tag_t    s1_tag_reg;
    logic [46:0] s1_plo_reg [LANES];
    logic [45:0] s1_phi_reg [LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tag_reg <= '0;
        end else if (en) begin
            s1_tag_reg <= s0_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < LANES; k++) begin
                s1_plo_reg[k] <= s0_mag_reg[k] * UDEG_RAD[17:0];
                s1_phi_reg[k] <= s0_mag_reg[k] * UDEG_RAD[34:18];
            end
        end
    end

    // ---------------- s2: combine, round and scale ----------------
    // latitudes take the full angle, differences the half angle
    logic [64:0] full_sum [LANES];
    logic [31:0] rad_next [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            full_sum[k] = {1'b0, s1_phi_reg[k], 18'd0} + 65'(s1_plo_reg[k]);
            if (k == LANE_LAT1 || k == LANE_LAT2) begin
                full_sum[k] = full_sum[k] + (65'd1 << (59 - F));
                rad_next[k] = 32'(full_sum[k] >> (60 - F));
            end else begin
                full_sum[k] = full_sum[k] + (65'd1 << (60 - F));
                rad_next[k] = 32'(full_sum[k] >> (61 - F));
            end
        end
    end

    hvd_tag_t    s2_tag_reg;
    logic [31:0] s2_rad_reg [LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_tag_reg <= '0;
        end else if (en) begin
            s2_tag_reg <= s1_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_rad_reg <= rad_next;
        end
    end

    // ---------------- s3: fold half differences past pi/2 ----------------
    hvd_z_t z_next [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if ((k == LANE_DLAT || k == LANE_DLON) && s2_rad_reg[k] > HALF_PI_F) begin
                z_next[k] = (s2_rad_reg[k] > PI_F) ? '0 : hvd_z_t'(PI_F - s2_rad_reg[k]);
            end else begin
                z_next[k] = hvd_z_t'(s2_rad_reg[k]);
            end
        end
    end

    hvd_tag_t s3_tag_reg;
    hvd_z_t   s3_z_reg [LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_tag_reg <= '0;
        end else if (en) begin
            s3_tag_reg <= s2_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_z_reg <= z_next;
        end
    end

    // ---------------- rotation row ----------------
    hvd_tag_t rot_tag [CORDIC_STEPS+1];
    hvd_xy_t  rot_x   [CORDIC_STEPS+1][LANES];
    hvd_xy_t  rot_y   [CORDIC_STEPS+1][LANES];
    hvd_z_t   rot_z   [CORDIC_STEPS+1][LANES];

    assign rot_tag[0] = s3_tag_reg;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            rot_x[0][k] = hvd_xy_t'(ONE);
            rot_y[0][k] = '0;
            rot_z[0][k] = s3_z_reg[k];
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        hvd_rot_cell #(
            .STEP (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .tag_in  (rot_tag[i]),
            .x_in    (rot_x[i]),
            .y_in    (rot_y[i]),
            .z_in    (rot_z[i]),
            .tag_out (rot_tag[i+1]),
            .x_out   (rot_x[i+1]),
            .y_out   (rot_y[i+1]),
            .z_out   (rot_z[i+1])
        );
    end

    // residue below zero reads as zero
    function automatic logic [ROOT_W-1:0] clamp_pos(input hvd_xy_t v);
        return v[XY_W-1] ? '0 : v[ROOT_W-1:0];
    endfunction

    logic [ROOT_W-1:0] cos1, cos2, sin_lat, sin_lon;

    assign cos1    = clamp_pos(rot_x[CORDIC_STEPS][LANE_LAT1]);
    assign cos2    = clamp_pos(rot_x[CORDIC_STEPS][LANE_LAT2]);
    assign sin_lat = clamp_pos(rot_y[CORDIC_STEPS][LANE_DLAT]);
    assign sin_lon = clamp_pos(rot_y[CORDIC_STEPS][LANE_DLON]);

    // ---------------- m1: squares and cosine product ----------------
    logic [2*ROOT_W-1:0] sq_lat, sq_lon, cos_prod;

    assign sq_lat   = sin_lat * sin_lat;
    assign sq_lon   = sin_lon * sin_lon;
    assign cos_prod = cos1 * cos2;

    // index 0: sin^2 dlat, 1: sin^2 dlon, 2: cos product
    hvd_tag_t    m1_tag_reg;
    logic [31:0] m1_v_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_tag_reg <= '0;
        end else if (en) begin
            m1_tag_reg <= rot_tag[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_v_reg[0] <= sq_lat[F+31:F];
            m1_v_reg[1] <= sq_lon[F+31:F];
            m1_v_reg[2] <= cos_prod[F+31:F];
        end
    end

    // ---------------- m2: gain correction partial products ----------------
    hvd_tag_t    m2_tag_reg;
    logic [61:0] m2_plo_reg [3];
    logic [61:0] m2_phi_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_tag_reg <= '0;
        end else if (en) begin
            m2_tag_reg <= m1_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                m2_plo_reg[k] <= m1_v_reg[k] * K2[29:0];
                m2_phi_reg[k] <= m1_v_reg[k] * K2[59:30];
            end
        end
    end

    // ---------------- m3: combine to floor(v * k2 / 2^60) ----------------
    logic [62:0] gsum [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            gsum[k] = 63'(m2_phi_reg[k]) + 63'(m2_plo_reg[k][61:30]);
        end
    end

    hvd_tag_t    m3_tag_reg;
    logic [31:0] m3_g_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m3_tag_reg <= '0;
        end else if (en) begin
            m3_tag_reg <= m2_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                m3_g_reg[k] <= gsum[k][61:30];
            end
        end
    end

    // ---------------- m4: cos1*cos2 times sin^2 dlon ----------------
    logic [63:0] cb_prod;

    assign cb_prod = m3_g_reg[2] * m3_g_reg[1];

    hvd_tag_t    m4_tag_reg;
    logic [31:0] m4_a_reg;
    logic [31:0] m4_cb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m4_tag_reg <= '0;
        end else if (en) begin
            m4_tag_reg <= m3_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m4_a_reg  <= m3_g_reg[0];
            m4_cb_reg <= cb_prod[F+31:F];
        end
    end

    // ---------------- m5: h, clamped to one, and 1 - h ----------------
    logic [32:0]       h_sum;
    logic [ROOT_W-1:0] h_next;

    assign h_sum  = {1'b0, m4_a_reg} + {1'b0, m4_cb_reg};
    assign h_next = (h_sum > 33'(ONE)) ? ONE : h_sum[ROOT_W-1:0];

    hvd_tag_t          m5_tag_reg;
    logic [ROOT_W-1:0] m5_h_reg;
    logic [ROOT_W-1:0] m5_hc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m5_tag_reg <= '0;
        end else if (en) begin
            m5_tag_reg <= m4_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m5_h_reg  <= h_next;
            m5_hc_reg <= ONE - h_next;
        end
    end

    // ---------------- square root row: lane 0 sqrt(1-h), lane 1 sqrt(h) ----------------
    localparam int SQ_CELLS = ROOT_W;

    hvd_tag_t          sq_tag  [SQ_CELLS+1];
    logic [RAD_W-1:0]  sq_rad  [SQ_CELLS+1][2];
    logic [ROOT_W-1:0] sq_root [SQ_CELLS+1][2];
    logic [REM_W-1:0]  sq_rem  [SQ_CELLS+1][2];

    assign sq_tag[0]     = m5_tag_reg;
    assign sq_rad[0][0]  = RAD_W'({m5_hc_reg, F'(0)});
    assign sq_rad[0][1]  = RAD_W'({m5_h_reg, F'(0)});
    assign sq_root[0][0] = '0;
    assign sq_root[0][1] = '0;
    assign sq_rem[0][0]  = '0;
    assign sq_rem[0][1]  = '0;

    for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
        hvd_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .tag_in   (sq_tag[i]),
            .rad_in   (sq_rad[i]),
            .root_in  (sq_root[i]),
            .rem_in   (sq_rem[i]),
            .tag_out  (sq_tag[i+1]),
            .rad_out  (sq_rad[i+1]),
            .root_out (sq_root[i+1]),
            .rem_out  (sq_rem[i+1])
        );
    end

    // ---------------- vectoring row: central angle ----------------
    hvd_tag_t vec_tag [CORDIC_STEPS+1];
    hvd_xy_t  vec_x   [CORDIC_STEPS+1];
    hvd_xy_t  vec_y   [CORDIC_STEPS+1];
    hvd_z_t   vec_z   [CORDIC_STEPS+1];

    assign vec_tag[0] = sq_tag[SQ_CELLS];
    assign vec_x[0]   = hvd_xy_t'(sq_root[SQ_CELLS][0]);
    assign vec_y[0]   = hvd_xy_t'(sq_root[SQ_CELLS][1]);
    assign vec_z[0]   = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
        hvd_vec_cell #(
            .STEP (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .tag_in  (vec_tag[i]),
            .x_in    (vec_x[i]),
            .y_in    (vec_y[i]),
            .z_in    (vec_z[i]),
            .tag_out (vec_tag[i+1]),
            .x_out   (vec_x[i+1]),
            .y_out   (vec_y[i+1]),
            .z_out   (vec_z[i+1])
        );
    end

    // ---------------- d1: angle times twice the radius ----------------
    hvd_z_t            theta_z;
    logic [ROOT_W-1:0] theta;

    assign theta_z = vec_z[CORDIC_STEPS];
    assign theta   = theta_z[Z_W-1] ? '0 : theta_z[ROOT_W-1:0];

    hvd_tag_t              d1_tag_reg;
    logic [ROOT_W+24:0]    d1_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_tag_reg <= '0;
        end else if (en) begin
            d1_tag_reg <= vec_tag[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_prod_reg <= theta * {radius_reg, 1'b0};
        end
    end

    // ---------------- rounding to meters, saturation ----------------
    logic [ROOT_W+25:0] d_round;
    logic [ROOT_W+25-F:0] d_meters;
    logic [25:0]        dist_next;

    always_comb begin
        d_round  = {1'b0, d1_prod_reg} + ((ROOT_W+26)'(1) << (F - 1));
        d_meters = d_round[ROOT_W+25:F];
        if (d1_tag_reg.bad) begin
            dist_next = '0;
        end else if (d_meters > (ROOT_W+26-F)'(DIST_MAX)) begin
            dist_next = DIST_MAX;
        end else begin
            dist_next = d_meters[25:0];
        end
    end

    // ---------------- output register and skid entry ----------------
    logic        push;
    logic [25:0] out_dist_reg, skid_dist_reg;
    logic        out_bad_reg, skid_bad_reg;

    assign push = en && d1_tag_reg.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_dist_reg <= skid_dist_reg;
                out_bad_reg  <= skid_bad_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || m_tready) begin
                out_dist_reg <= dist_next;
                out_bad_reg  <= d1_tag_reg.bad;
            end else begin
                skid_dist_reg <= dist_next;
                skid_bad_reg  <= d1_tag_reg.bad;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_dist_reg};
    assign m_tuser  = out_bad_reg;

endmodule

`default_nettype wire
